// File: src/ppsb_pkg.sv
// package: shared types and constants for the point projection screen box block
`timescale 1ns / 1ps
package ppsb_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ROW0_XY = 3'd0;
    localparam logic [2:0] REG_ROW0_ZW = 3'd1;
    localparam logic [2:0] REG_ROW1_XY = 3'd2;
    localparam logic [2:0] REG_ROW1_ZW = 3'd3;
    localparam logic [2:0] REG_ROW3_XY = 3'd4;
    localparam logic [2:0] REG_ROW3_ZW = 3'd5;
    localparam logic [2:0] REG_SCREEN  = 3'd6;
    localparam logic [2:0] REG_HEAD_HT = 3'd7;

    localparam logic [31:0] SCREEN_RESET = 32'd70780800;
    localparam logic [31:0] HEAD_RESET   = 32'd1769472;
    localparam logic signed [31:0] W_MIN = 32'sd6554;

    // divider: 57-bit numerator magnitude, 32-bit divisor, radix 2
    localparam int NUM_W = 57;
    localparam int QUO_W = 57;
    // bits retired per divider stage
    localparam int DIV_BPS = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_BPS - 1) / DIV_BPS;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [5:0]         item_tag;
    } t_in;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] feet_screen_x;
        logic signed [31:0] feet_screen_y;
        logic signed [31:0] head_screen_x;
        logic signed [31:0] head_screen_y;
        logic signed [31:0] box_left;
        logic signed [31:0] box_right;
        logic [30:0]        box_height;
        logic [5:0]         result_tag;
    } t_out;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
        else                            r = v[31:0];
        return r;
    endfunction

endpackage

// File: src/ppsb_div.sv
// pipelined signed divider with truncation toward zero and 32-bit saturation
`timescale 1ns / 1ps
module ppsb_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [ppsb_pkg::NUM_W:0] i_num,
    input  logic signed [31:0]          i_den,
    output logic signed [31:0]          o_quo
);
    import ppsb_pkg::*;

    localparam int SW = NUM_W + 32;

    logic [NUM_W-1:0] r_q   [DIV_STAGES+1];
    logic [32:0]      r_rem [DIV_STAGES+1];
    logic [31:0]      r_den [DIV_STAGES+1];
    logic             r_neg [DIV_STAGES+1];

    // magnitudes; the divisor is always positive here
    logic [NUM_W-1:0] num_abs;
    assign num_abs = i_num[NUM_W] ? NUM_W'(-i_num) : NUM_W'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]   <= num_abs;
            r_rem[0] <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_num[NUM_W];
        end
    end

    // restoring division, DIV_BPS quotient bits per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
        logic [NUM_W-1:0] q;
        logic [32:0]      rm;
        always_comb begin
            q  = r_q[s];
            rm = r_rem[s];
            for (int b = 0; b < DIV_BPS; b++) begin
                // the last stage retires only the bits that are left
                if (s * DIV_BPS + b < NUM_W) begin
                    rm = {rm[31:0], q[NUM_W-1]};
                    q  = {q[NUM_W-2:0], 1'b0};
                    if (rm >= {1'b0, r_den[s]}) begin
                        rm   = rm - {1'b0, r_den[s]};
                        q[0] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1]   <= q;
                r_rem[s+1] <= rm;
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // sign and saturate; XS counts the idle bit slots of the last stage
    localparam int XS = DIV_STAGES * DIV_BPS - NUM_W;
    logic [NUM_W-1:0] qm;
    logic signed [NUM_W+1:0] qs;
    always_comb begin
        qm = r_q[DIV_STAGES];
        qs = r_neg[DIV_STAGES] ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
        if (qs > $signed((NUM_W+2)'(32'h7FFF_FFFF)))       o_quo = 32'sh7FFF_FFFF;
        else if (qs < -$signed((NUM_W+2)'(33'h0_8000_0000))) o_quo = 32'sh8000_0000;
        else                                                  o_quo = qs[31:0];
    end

    logic unused;
    assign unused = ^{r_rem[DIV_STAGES], r_den[DIV_STAGES], XS[0], SW[0]};
endmodule

// File: src/point_projection_screen_box_top.sv
// top level: projects a foot point and a head point to screen and forms a box
`timescale 1ns / 1ps
// Each request carries a Q16.16 foot point; the head point is the foot point raised by the
// head height register. Both points go through rows 0, 1 and 3 of the view matrix in a
// multiply stage and a sum stage, then a numerator stage feeds four pipelined dividers
// (screen x and y for both points), followed by two box stages. One request is taken every
// cycle unless the output is stalled; the 57-bit divider pipeline has an input register plus
// 15 stages of up to four quotient bits each. i_out_stall from the output side freezes the
// whole pipeline; o_in_stall is high only while a result is held and the pipe is stalled.
// The user must write configuration only while the block is idle; the block itself does
// not enforce this.
module point_projection_screen_box_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ppsb_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ppsb_pkg::t_out    o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data
);
    import ppsb_pkg::*;

    localparam int LAT = 5 + DIV_STAGES + 2;

    // configuration registers
    logic [63:0] r_mat [6];
    logic [31:0] r_scr, r_hh;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_mat[i] <= '0;
            r_scr <= SCREEN_RESET;
            r_hh  <= HEAD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW0_XY, REG_ROW0_ZW, REG_ROW1_XY,
                REG_ROW1_ZW, REG_ROW3_XY, REG_ROW3_ZW: r_mat[i_cfg_index] <= i_cfg_data;
                REG_SCREEN:  r_scr <= i_cfg_data[31:0];
                REG_HEAD_HT: r_hh  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances when the output is not held
    logic en;
    assign en = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    logic r_v [LAT];
    logic [5:0] r_tag [LAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_v[i] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_in_valid;
            for (int i = 1; i < LAT; i++) r_v[i] <= r_v[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= i_in_data.item_tag;
            for (int i = 1; i < LAT-1; i++) r_tag[i] <= r_tag[i-1];
        end
    end

    function automatic logic signed [31:0] ment(input logic [63:0] m [6], input int r,
                                                input int c);
        logic [63:0] w;
        w = m[r*2 + c/2];
        return (c % 2 == 1) ? w[63:32] : w[31:0];
    endfunction

    // stage 0: head z and input capture
    logic signed [31:0] r0_x, r0_y, r0_fz, r0_hz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x  <= i_in_data.pos_x;
            r0_y  <= i_in_data.pos_y;
            r0_fz <= i_in_data.pos_z;
            r0_hz <= sat34(34'(i_in_data.pos_z) + 34'($signed(r_hh)));
        end
    end

    // stage 1: products floored to Q16.16 (point p: 0 foot, 1 head; row r)
    logic signed [47:0] r1_p [2][3][3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r1_p[0][r][0] <= 48'((64'(r0_x) * 64'(ment(r_mat, r, 0))) >>> 16);
                r1_p[0][r][1] <= 48'((64'(r0_y) * 64'(ment(r_mat, r, 1))) >>> 16);
                r1_p[0][r][2] <= 48'((64'(r0_fz) * 64'(ment(r_mat, r, 2))) >>> 16);
                r1_p[1][r][0] <= 48'((64'(r0_x) * 64'(ment(r_mat, r, 0))) >>> 16);
                r1_p[1][r][1] <= 48'((64'(r0_y) * 64'(ment(r_mat, r, 1))) >>> 16);
                r1_p[1][r][2] <= 48'((64'(r0_hz) * 64'(ment(r_mat, r, 2))) >>> 16);
            end
        end
    end

    // stage 2: sums and saturation to clip values
    logic signed [31:0] r2_c [2][3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                for (int r = 0; r < 3; r++) begin
                    logic signed [49:0] s;
                    s = 50'(r1_p[p][r][0]) + 50'(r1_p[p][r][1]) + 50'(r1_p[p][r][2])
                      + 50'(ment(r_mat, r, 3));
                    if (s > 50'sh7FFF_FFFF)       r2_c[p][r] <= 32'sh7FFF_FFFF;
                    else if (s < -50'sh8000_0000) r2_c[p][r] <= 32'sh8000_0000;
                    else                          r2_c[p][r] <= s[31:0];
                end
            end
        end
    end

    // stage 3: numerators (33-bit sum or difference times 16-bit size times 128)
    logic signed [NUM_W:0] r3_n [2][2];
    logic signed [31:0]    r3_w [2];
    logic                  r3_ok;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                r3_n[p][0] <= (NUM_W+1)'((34'(r2_c[p][0]) + 34'(r2_c[p][2]))
                              * $signed({1'b0, r_scr[15:0]})) <<< 7;
                r3_n[p][1] <= (NUM_W+1)'((34'(r2_c[p][2]) - 34'(r2_c[p][1]))
                              * $signed({1'b0, r_scr[31:16]})) <<< 7;
                // a clipped point divides by one to keep the divider harmless
                r3_w[p] <= (r2_c[p][2] < W_MIN) ? 32'sd1 : r2_c[p][2];
            end
            r3_ok <= (r2_c[0][2] >= W_MIN) && (r2_c[1][2] >= W_MIN)
                     && (r_scr[15:0] != '0) && (r_scr[31:16] != '0);
        end
    end

    // dividers: foot x, foot y, head x, head y
    logic signed [31:0] q [2][2];
    for (genvar p = 0; p < 2; p++) begin : g_pt
        for (genvar a = 0; a < 2; a++) begin : g_ax
            ppsb_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r3_n[p][a]),
                .i_den (r3_w[p]),
                .o_quo (q[p][a])
            );
        end
    end

    logic r_ok [DIV_STAGES+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok[0] <= r3_ok;
            for (int i = 1; i <= DIV_STAGES; i++) r_ok[i] <= r_ok[i-1];
        end
    end

    // box stage a: box height
    logic signed [31:0] r5_fx, r5_fy, r5_hx, r5_hy;
    logic [30:0]        r5_bh;
    logic               r5_ok;
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic signed [32:0] d;
            d = 33'(q[0][1]) - 33'(q[1][1]);
            if (d < 0) d = -d;
            r5_bh <= (d > 33'sh7FFF_FFFF) ? 31'h7FFF_FFFF : d[30:0];
            r5_fx <= q[0][0]; r5_fy <= q[0][1];
            r5_hx <= q[1][0]; r5_hy <= q[1][1];
            r5_ok <= r_ok[DIV_STAGES];
        end
    end

    // box stage b: half width, edges and output register
    logic [34:0] half_m;
    logic [30:0] half;
    assign half_m = ({4'b0, r5_bh} * 35'd3);
    // divide by ten via reciprocal, exact for products below 2^34
    logic [67:0] prod;
    assign prod = 68'(half_m) * 68'h0_CCCC_CCCD;
    assign half = 31'(prod >> 35);

    t_out r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.result_tag <= r_tag[LAT-2];
            r_out.visible    <= r5_ok;
            if (r5_ok) begin
                r_out.feet_screen_x <= r5_fx;
                r_out.feet_screen_y <= r5_fy;
                r_out.head_screen_x <= r5_hx;
                r_out.head_screen_y <= r5_hy;
                r_out.box_height    <= r5_bh;
                r_out.box_left  <= sat34(34'(r5_hx) - 34'($signed({1'b0, half})));
                r_out.box_right <= sat34(34'(r5_hx) + 34'($signed({1'b0, half})));
            end else begin
                r_out.feet_screen_x <= '0;
                r_out.feet_screen_y <= '0;
                r_out.head_screen_x <= '0;
                r_out.head_screen_y <= '0;
                r_out.box_height    <= '0;
                r_out.box_left      <= '0;
                r_out.box_right     <= '0;
            end
        end
    end
    assign o_out_valid = r_v[LAT-1];
    assign o_out_data  = r_out;

`ifndef SYNTH
    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("held result changed");
    // invisible results carry a zero box height
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.visible |-> o_out_data.box_height == '0)
        else $error("invisible result has a box");
    // input stall only follows a held output
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("spurious input stall");
`endif
endmodule

// File: sim/tb_top.sv
// testbench: point projection screen box block, checked against an in-bench projection predictor
`timescale 1ns / 1ps
module tb_top;
    import ppsb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_ROW0_XY;
    logic [63:0] i_cfg_data = '0;

    point_projection_screen_box_top uut (.*);

    // bench copy of the configuration
    logic [63:0] view_mat [6];
    logic [31:0] screen_sz;
    logic [31:0] head_ht;

    t_out proj_q [$];
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   n_fail = 0;
    int   n_results = 0;
    int   n_visible = 0;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_TEN = 32'h000A_0000;

    typedef struct {
        int          phase;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  tag;
        bit          typed;
    } t_row;

    // directed stimulus: phase 0 reset config, 1 simple perspective, 2 negative head,
    // 3 zero width screen, 4 largest screen and head
    t_row rows [] = '{
        '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0,  1},
        '{0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd63, 1},
        '{0, 32'h0,         32'h0,         32'h0,         6'd21, 1},
        '{0, Q_ONE,         Q_TEN,         Q_ONE,         6'd42, 1},
        '{1, 32'h0,         Q_TEN,         32'h0,         6'd1,  0},
        '{1, 32'h0005_0000, Q_TEN,         32'hFFF6_0000, 6'd2,  0},
        '{1, 32'h0,         32'hFFEC_0000, 32'h0,         6'd3,  0},
        '{1, 32'h8000_0000, 32'd13107,     32'h0,         6'd4,  0},
        '{1, 32'h7FFF_FFFF, 32'd13107,     32'h0,         6'd5,  0},
        '{1, 32'h0,         32'd6554,      32'hFFE5_0000, 6'd6,  0},
        '{1, 32'h0,         32'd6553,      32'hFFE5_0000, 6'd7,  0},
        '{1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd8,  0},
        '{1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 6'd9,  0},
        '{2, 32'h0,         Q_TEN,         32'h0,         6'd10, 0},
        '{2, 32'h0,         32'h7FFF_FFFF, 32'h8000_0000, 6'd11, 0},
        '{2, 32'h0003_0000, 32'h7FFF_0000, 32'h0,         6'd12, 0},
        '{3, 32'h0,         Q_TEN,         32'h0,         6'd13, 0},
        '{4, 32'h0,         Q_TEN,         32'h0,         6'd14, 0},
        '{4, 32'h7FFF_FFFF, Q_ONE,         32'h0,         6'd15, 0},
        '{4, 32'h8000_0000, Q_ONE,         32'h7FFF_FFFF, 6'd16, 0}
    };

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // signed Q16.16 matrix entry; r is stored row 0..2, c is column 0..3
    function automatic longint mat_entry(int r, int c);
        logic [63:0] w;
        logic [31:0] half;
        w = view_mat[r * 2 + c / 2];
        half = (c % 2) ? w[63:32] : w[31:0];
        return longint'($signed(half));
    endfunction

    function automatic longint clip_value(int r, longint x, longint y, longint z);
        longint s;
        s = ((x * mat_entry(r, 0)) >>> 16) + ((y * mat_entry(r, 1)) >>> 16)
            + ((z * mat_entry(r, 2)) >>> 16) + mat_entry(r, 3);
        return sat32(s);
    endfunction

    // one point to pixels, returns 0 when clipped by w
    function automatic bit to_screen(longint x, longint y, longint z, longint wpx, longint hpx,
                                     output longint sx, output longint sy);
        longint cx, cy, cw;
        cx = clip_value(0, x, y, z);
        cy = clip_value(1, x, y, z);
        cw = clip_value(2, x, y, z);
        sx = 0;
        sy = 0;
        if (cw < longint'(W_MIN)) return 0;
        sx = sat32(((cx + cw) * wpx * 128) / cw);
        sy = sat32(((cw - cy) * hpx * 128) / cw);
        return 1;
    endfunction

    function automatic t_out project_box(t_in p);
        t_out   r;
        longint px, py, pz, hz, wpx, hpx, fx, fy, hx, hy, bh, half;
        bit     vis, head_ok, feet_ok;
        px = longint'(p.pos_x);
        py = longint'(p.pos_y);
        pz = longint'(p.pos_z);
        hz = sat32(pz + longint'($signed(head_ht)));
        wpx = longint'(screen_sz[15:0]);
        hpx = longint'(screen_sz[31:16]);
        vis = 0;
        fx = 0; fy = 0; hx = 0; hy = 0;
        r = '0;
        if (wpx != 0 && hpx != 0) begin
            head_ok = to_screen(px, py, hz, wpx, hpx, hx, hy);
            feet_ok = to_screen(px, py, pz, wpx, hpx, fx, fy);
            vis = head_ok && feet_ok;
        end
        if (vis) begin
            bh = fy - hy;
            if (bh < 0) bh = -bh;
            if (bh > 64'sd2147483647) bh = 64'sd2147483647;
            half = (bh * 3) / 10;
            r.visible = 1'b1;
            r.feet_screen_x = fx[31:0];
            r.feet_screen_y = fy[31:0];
            r.head_screen_x = hx[31:0];
            r.head_screen_y = hy[31:0];
            r.box_left = 32'(sat32(hx - half));
            r.box_right = 32'(sat32(hx + half));
            r.box_height = bh[30:0];
        end
        r.result_tag = p.item_tag;
        return r;
    endfunction

    // accepted requests feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            proj_q.push_back(project_box(i_in_data));
    end

    task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s mismatch: expected %h, actual %h", name, e, a);
            n_fail++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (proj_q.size() == 0) begin
                $error("result with no request waiting, tag %0d", o_out_data.result_tag);
                n_fail++;
            end else begin
                e = proj_q.pop_front();
                cmp("visible", 32'(e.visible), 32'(o_out_data.visible));
                cmp("feet_screen_x", e.feet_screen_x, o_out_data.feet_screen_x);
                cmp("feet_screen_y", e.feet_screen_y, o_out_data.feet_screen_y);
                cmp("head_screen_x", e.head_screen_x, o_out_data.head_screen_x);
                cmp("head_screen_y", e.head_screen_y, o_out_data.head_screen_y);
                cmp("box_left", e.box_left, o_out_data.box_left);
                cmp("box_right", e.box_right, o_out_data.box_right);
                cmp("box_height", 32'(e.box_height), 32'(o_out_data.box_height));
                cmp("result_tag", 32'(e.result_tag), 32'(o_out_data.result_tag));
                n_results++;
                if (o_out_data.visible) n_visible++;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // one write, then valid is dropped on the configuration channel before the task returns
    task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SCREEN:  screen_sz = data[31:0];
            REG_HEAD_HT: head_ht = data[31:0];
            default:     view_mat[idx] = data;
        endcase
        @(posedge i_clk);
    endtask

    // let the pipe empty before touching configuration
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (proj_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send(t_in p);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= p;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic directed_phase(int ph);
        case (ph)
            1: begin
                // cx = x, cy = z, cw = y + z
                cfg_write(REG_ROW0_XY, {32'h0, Q_ONE});
                cfg_write(REG_ROW0_ZW, 64'h0);
                cfg_write(REG_ROW1_XY, 64'h0);
                cfg_write(REG_ROW1_ZW, {32'h0, Q_ONE});
                cfg_write(REG_ROW3_XY, {Q_ONE, 32'h0});
                cfg_write(REG_ROW3_ZW, {32'h0, Q_ONE});
            end
            2: cfg_write(REG_HEAD_HT, 64'h8000_0000);
            3: cfg_write(REG_SCREEN, 64'h0438_0000);
            4: begin
                cfg_write(REG_SCREEN, 64'hFFFF_FFFF);
                cfg_write(REG_HEAD_HT, 64'h7FFF_FFFF);
            end
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_entry();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(32'h40000) - 32'h20000;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(7) == 0) return $urandom;
        return $urandom_range(32'h80_0000) - 32'h40_0000;
    endfunction

    task automatic random_config(int set_no);
        logic [31:0] scr, hh;
        cfg_write(REG_ROW0_XY, {rand_entry(), rand_entry()});
        cfg_write(REG_ROW0_ZW, {rand_entry(), rand_entry()});
        cfg_write(REG_ROW1_XY, {rand_entry(), rand_entry()});
        cfg_write(REG_ROW1_ZW, {rand_entry(), rand_entry()});
        cfg_write(REG_ROW3_XY, {rand_entry(), rand_entry()});
        // positive w bias keeps most points in front of the camera
        cfg_write(REG_ROW3_ZW, {32'($urandom_range(32'h10_0000, 32'h1_0000)), rand_entry()});
        scr = {16'($urandom_range(4096, 1)), 16'($urandom_range(4096, 1))};
        hh = $urandom_range(32'h80_0000) - 32'h40_0000;
        case (set_no)
            0: begin scr = 32'hFFFF_FFFF; hh = 32'h7FFF_FFFF; end
            1: hh = 32'h8000_0000;
            2: scr = SCREEN_RESET;
            3: scr = 32'h0000_0400;
            5: hh = 32'h0;
            default: ;
        endcase
        cfg_write(REG_SCREEN, {32'h0, scr});
        cfg_write(REG_HEAD_HT, {32'h0, hh});
    endtask

    // main sequence
    initial begin
        t_in  p;
        t_out clipped;
        int   cur_phase;
        for (int i = 0; i < 6; i++) view_mat[i] = '0;
        screen_sz = SCREEN_RESET;
        head_ht = HEAD_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        cur_phase = 0;
        foreach (rows[i]) begin
            if (rows[i].phase != cur_phase) begin
                drain();
                cur_phase = rows[i].phase;
                directed_phase(cur_phase);
            end
            p.pos_x = rows[i].x;
            p.pos_y = rows[i].y;
            p.pos_z = rows[i].z;
            p.item_tag = rows[i].tag;
            // with the all-zero matrix after reset w is zero, so every point is clipped
            clipped = '0;
            clipped.result_tag = p.item_tag;
            if (rows[i].typed && project_box(p) !== clipped) begin
                $error("reset config should clip tag %0d", p.item_tag);
                n_fail++;
            end
            send(p);
        end
        drain();

        // random part: eight settings, idling pattern cycles through four phases
        for (int s = 0; s < 8; s++) begin
            random_config(s);
            case (s % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            for (int k = 0; k < 210; k++) begin
                p.pos_x = rand_coord();
                p.pos_y = rand_coord();
                p.pos_z = rand_coord();
                p.item_tag = $urandom;
                send(p);
            end
            idle_pct = 0;
            drain();
            stall_pct = 0;
        end

        $display("covered %0d results, %0d visible, over %0d register settings",
                 n_results, n_visible, 13);
        if (n_fail == 0)
            $display("point_projection_screen_box_top test passed");
        else
            $display("point_projection_screen_box_top test failed");
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("point_projection_screen_box_top test failed");
        $finish;
    end

endmodule

// File: sim.f
src/ppsb_pkg.sv
src/ppsb_div.sv
src/point_projection_screen_box_top.sv
sim/tb_top.sv
